### rtl/core/lru_page_replacement_macros.svh
// ----------------------------------------------------------------------------
// lru page replacement assertion macros
// concurrent checks on a clock with a synchronous active high reset
// ----------------------------------------------------------------------------
`ifndef LRU_PAGE_REPLACEMENT_MACROS_SVH
`define LRU_PAGE_REPLACEMENT_MACROS_SVH

// consequent holds in the same cycle as the antecedent
`define LRU_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent holds in the cycle after the antecedent
`define LRU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/lru_pkg.sv
// ----------------------------------------------------------------------------
// lru_pkg
// shared types for the lru frame manager: cell chain link, update command
// and sequencer states
// ----------------------------------------------------------------------------
package lru_pkg;

   // widest frame index and rank over the supported frame counts
   localparam int LRU_IDX_W_MAX = 6;

   typedef enum logic [1:0] {
      LRU_IDLE,
      LRU_SCAN,
      LRU_COMMIT
   } lru_state_type;

   // search result rippling from cell to cell
   typedef struct packed {
      logic                     found;
      logic [LRU_IDX_W_MAX-1:0] hit_idx;
      logic [LRU_IDX_W_MAX-1:0] hit_rank;
      logic                     best_valid;
      logic [LRU_IDX_W_MAX-1:0] best_rank;
      logic [LRU_IDX_W_MAX-1:0] best_idx;
   } lru_link_type;

   // update broadcast to every cell
   typedef struct packed {
      logic                     apply;
      logic                     write;
      logic                     age_all;
      logic [LRU_IDX_W_MAX-1:0] frame;
      logic [LRU_IDX_W_MAX-1:0] limit;
   } lru_cmd_type;

endpackage

### rtl/core/lru_cell.sv
// ----------------------------------------------------------------------------
// lru_cell
// one frame: page, valid bit and recency rank, plus one registered hop of
// the hit / victim search chain
// ----------------------------------------------------------------------------
module lru_cell #(
   parameter int FRAME_COUNT = 16,
   parameter int PAGE_BITS   = 16,
   parameter int CELL_INDEX  = 0
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   active,
   input  logic [PAGE_BITS-1:0]   lookup_page,
   input  lru_pkg::lru_cmd_type   cmd,
   input  lru_pkg::lru_link_type  up_link,
   input  logic [PAGE_BITS-1:0]   up_page,
   output lru_pkg::lru_link_type  dn_link,
   output logic [PAGE_BITS-1:0]   dn_page
);

   localparam int IDX_W = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
   localparam int W     = lru_pkg::LRU_IDX_W_MAX;
   localparam logic [IDX_W-1:0] RANK_TOP = IDX_W'(FRAME_COUNT - 1);
   localparam logic [W-1:0]     SELF     = W'(CELL_INDEX);
   localparam bit               IS_FIRST = (CELL_INDEX == 0);

   logic [PAGE_BITS-1:0]  page_ff, page_in;
   logic                  valid_ff, valid_in;
   logic [IDX_W-1:0]      rank_ff, rank_in;
   lru_pkg::lru_link_type link_ff, link_in;
   logic [PAGE_BITS-1:0]  link_page_ff, link_page_in;

   logic [W-1:0] rank_wide;
   logic         hit_take;
   logic         vic_take;

   always_comb begin
      rank_wide = W'(rank_ff);
      hit_take  = !up_link.found && active && valid_ff && (page_ff == lookup_page);
      vic_take  = IS_FIRST || (active && (rank_wide > up_link.best_rank));

      link_in      = up_link;
      link_page_in = up_page;
      if (hit_take) begin
         link_in.found    = 1'b1;
         link_in.hit_idx  = SELF;
         link_in.hit_rank = rank_wide;
      end
      if (vic_take) begin
         link_in.best_valid = valid_ff;
         link_in.best_rank  = rank_wide;
         link_in.best_idx   = SELF;
         link_page_in       = page_ff;
      end

      page_in  = page_ff;
      valid_in = valid_ff;
      rank_in  = rank_ff;
      if (cmd.apply) begin
         if (cmd.frame == SELF) begin
            rank_in = '0;
            if (cmd.write) begin
               page_in  = lookup_page;
               valid_in = 1'b1;
            end
         end else if (active && valid_ff && (cmd.age_all || (rank_wide < cmd.limit))
                      && (rank_ff != RANK_TOP)) begin
            rank_in = rank_ff + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         rank_ff  <= '0;
         link_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         rank_ff  <= rank_in;
         link_ff  <= link_in;
      end
   end

   always_ff @(posedge clock) begin
      page_ff      <= page_in;
      link_page_ff <= link_page_in;
   end

   assign dn_link = link_ff;
   assign dn_page = link_page_ff;

endmodule

### rtl/core/lru_page_replacement.sv
// ----------------------------------------------------------------------------
// lru_page_replacement
// fully associative lru frame manager built as a chain of frame cells
//
//   channel  | direction | handshake             | payload
//   req      | in        | req_valid / req_stall | req_page_number
//   rsp      | out       | rsp_valid / rsp_stall | hit, frame, eviction, totals
//   csr      | in        | csr_write_en          | csr_write_data (frames in use)
//
// requests are handled one at a time: the search ripples one cell per
// cycle through FRAME_COUNT cells, then a commit updates all frames.
// a new request is taken while the previous response still waits; commit
// waits for the response register to be free.
// synchronous reset empties all frames and clears both totals at once.
// ----------------------------------------------------------------------------
`include "lru_page_replacement_macros.svh"

module lru_page_replacement #(
   parameter int FRAME_COUNT = 16,
   parameter int PAGE_BITS   = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [PAGE_BITS-1:0] req_page_number,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_hit,
   output logic [3:0]           rsp_frame_index,
   output logic                 rsp_evicted_valid,
   output logic [PAGE_BITS-1:0] rsp_evicted_page,
   output logic [31:0]          rsp_fault_total,
   output logic [31:0]          rsp_hit_total,
   input  logic                 csr_write_en,
   input  logic [4:0]           csr_write_data
);

   localparam int IDX_W = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
   localparam int CNT_W = $clog2(FRAME_COUNT + 1);
   localparam int CMP_W = (CNT_W > 5) ? CNT_W : 5;
   localparam int W     = lru_pkg::LRU_IDX_W_MAX;
   localparam logic [IDX_W-1:0] SCAN_LAST = IDX_W'(FRAME_COUNT - 1);
   localparam logic [CMP_W-1:0] FC_CMP    = CMP_W'(FRAME_COUNT);
   localparam logic [31:0]      COUNT_MAX = '1;

   lru_pkg::lru_state_type state_ff, state_in;
   logic [IDX_W-1:0]       scan_cnt_ff, scan_cnt_in;
   logic [PAGE_BITS-1:0]   req_page_ff, req_page_in;
   logic [4:0]             frames_ff, frames_in;
   logic [CNT_W-1:0]       filled_ff, filled_in;
   logic [31:0]            fault_count_ff, fault_count_in;
   logic [31:0]            hit_count_ff, hit_count_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_hit_ff, rsp_hit_in;
   logic [3:0]             rsp_frame_ff, rsp_frame_in;
   logic                   rsp_ev_valid_ff, rsp_ev_valid_in;
   logic [PAGE_BITS-1:0]   rsp_ev_page_ff, rsp_ev_page_in;

   logic [CMP_W-1:0]       frames_wide;
   logic [CNT_W-1:0]       n_eff;
   logic [FRAME_COUNT-1:0] active;
   logic                   commit_go;
   logic                   miss_fill;
   logic                   ev_valid;
   lru_pkg::lru_cmd_type   cmd;
   lru_pkg::lru_link_type  tail;
   lru_pkg::lru_link_type  link_chain [FRAME_COUNT+1];
   logic [PAGE_BITS-1:0]   page_chain [FRAME_COUNT+1];

   // clamp frames in use to 1..FRAME_COUNT
   always_comb begin
      frames_wide = CMP_W'(frames_ff);
      if (frames_wide == '0) begin
         n_eff = CNT_W'(1);
      end else if (frames_wide > FC_CMP) begin
         n_eff = CNT_W'(FRAME_COUNT);
      end else begin
         n_eff = CNT_W'(frames_wide);
      end
   end

   assign link_chain[0] = '0;
   assign page_chain[0] = '0;

   for (genvar j = 0; j < FRAME_COUNT; j++) begin : g_cell
      assign active[j] = (CNT_W'(j) < n_eff);

      lru_cell #(
         .FRAME_COUNT (FRAME_COUNT),
         .PAGE_BITS   (PAGE_BITS),
         .CELL_INDEX  (j)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .active      (active[j]),
         .lookup_page (req_page_ff),
         .cmd         (cmd),
         .up_link     (link_chain[j]),
         .up_page     (page_chain[j]),
         .dn_link     (link_chain[j+1]),
         .dn_page     (page_chain[j+1])
      );
   end

   assign tail = link_chain[FRAME_COUNT];

   // sequencer
   always_comb begin
      state_in    = state_ff;
      scan_cnt_in = scan_cnt_ff;
      req_page_in = req_page_ff;
      req_stall   = 1'b1;
      commit_go   = 1'b0;
      case (state_ff)
         lru_pkg::LRU_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               req_page_in = req_page_number;
               scan_cnt_in = '0;
               state_in    = lru_pkg::LRU_SCAN;
            end
         end
         lru_pkg::LRU_SCAN: begin
            scan_cnt_in = scan_cnt_ff + IDX_W'(1);
            if (scan_cnt_ff == SCAN_LAST) begin
               state_in = lru_pkg::LRU_COMMIT;
            end
         end
         lru_pkg::LRU_COMMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               commit_go = 1'b1;
               state_in  = lru_pkg::LRU_IDLE;
            end
         end
         default: begin
            state_in = lru_pkg::LRU_IDLE;
         end
      endcase
   end

   // commit decision
   always_comb begin
      miss_fill = !tail.found && (filled_ff < n_eff);
      ev_valid  = !tail.found && !miss_fill && tail.best_valid;

      cmd.apply   = commit_go;
      cmd.write   = !tail.found;
      cmd.age_all = !tail.found;
      cmd.limit   = tail.hit_rank;
      if (tail.found) begin
         cmd.frame = tail.hit_idx;
      end else if (miss_fill) begin
         cmd.frame = W'(filled_ff);
      end else begin
         cmd.frame = tail.best_idx;
      end

      filled_in       = filled_ff;
      fault_count_in  = fault_count_ff;
      hit_count_in    = hit_count_ff;
      rsp_hit_in      = rsp_hit_ff;
      rsp_frame_in    = rsp_frame_ff;
      rsp_ev_valid_in = rsp_ev_valid_ff;
      rsp_ev_page_in  = rsp_ev_page_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      if (commit_go) begin
         rsp_valid_in    = 1'b1;
         rsp_hit_in      = tail.found;
         rsp_frame_in    = cmd.frame[3:0];
         rsp_ev_valid_in = ev_valid;
         rsp_ev_page_in  = ev_valid ? page_chain[FRAME_COUNT] : '0;
         if (tail.found) begin
            if (hit_count_ff != COUNT_MAX) begin
               hit_count_in = hit_count_ff + 32'd1;
            end
         end else if (fault_count_ff != COUNT_MAX) begin
            fault_count_in = fault_count_ff + 32'd1;
         end
         if (miss_fill) begin
            filled_in = filled_ff + CNT_W'(1);
         end
      end

      frames_in = csr_write_en ? csr_write_data : frames_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= lru_pkg::LRU_IDLE;
         scan_cnt_ff    <= '0;
         frames_ff      <= 5'd4;
         filled_ff      <= '0;
         fault_count_ff <= '0;
         hit_count_ff   <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         scan_cnt_ff    <= scan_cnt_in;
         frames_ff      <= frames_in;
         filled_ff      <= filled_in;
         fault_count_ff <= fault_count_in;
         hit_count_ff   <= hit_count_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_page_ff     <= req_page_in;
      rsp_hit_ff      <= rsp_hit_in;
      rsp_frame_ff    <= rsp_frame_in;
      rsp_ev_valid_ff <= rsp_ev_valid_in;
      rsp_ev_page_ff  <= rsp_ev_page_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_hit           = rsp_hit_ff;
   assign rsp_frame_index   = rsp_frame_ff;
   assign rsp_evicted_valid = rsp_ev_valid_ff;
   assign rsp_evicted_page  = rsp_ev_page_ff;
   assign rsp_fault_total   = fault_count_ff;
   assign rsp_hit_total     = hit_count_ff;

   `LRU_ASSERT_NOW(a_filled_bound, clock, reset, 1'b1, filled_ff <= CNT_W'(FRAME_COUNT), "filled count beyond frame count")
   `LRU_ASSERT_NEXT(a_commit_rsp, clock, reset, commit_go, rsp_valid_ff, "commit without response")
   `LRU_ASSERT_NOW(a_evict_miss, clock, reset, rsp_valid_ff && rsp_evicted_valid, !rsp_hit, "eviction on a hit")
   `LRU_ASSERT_NEXT(a_totals_hold, clock, reset, !commit_go, $stable(hit_count_ff) && $stable(fault_count_ff), "totals moved outside commit")

endmodule
